// ===== hw/rtl/svalloc_pkg.sv =====
// Shared constants, codes and control structs for the voice allocator.
// Used by svalloc_ctrl, svalloc_dp and synth_voice_allocator; no dependencies.
package svalloc_pkg;

  // Sizing
  localparam int VOICES      = 8;
  localparam int NOTES       = 128;
  localparam int VOICE_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int NOTE_IDX_W  = $clog2(NOTES);
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int VOICE_OUT_W = 3;

  // Stream packing
  localparam int IN_DATA_BITS  = NOTE_W + VEL_W;
  localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int IN_PAD_W      = IN_TDATA_W - IN_DATA_BITS;
  localparam int OUT_NOTE_LSB  = VOICE_OUT_W;
  localparam int OUT_VEL_LSB   = VOICE_OUT_W + NOTE_W;
  localparam int OUT_DATA_BITS = VOICE_OUT_W + NOTE_W + VEL_W;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_DATA_BITS;

  // Event codes (input op and output kind share the encoding)
  localparam logic KIND_NOTE_ON  = 1'b0;
  localparam logic KIND_NOTE_OFF = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // take the input transfer, start the map lookup
    logic emit_steal;  // send note-off for the note held by the pointed voice
    logic emit_on;     // record the new note and send its note-on
    logic emit_off;    // free the mapped voice and send its note-off
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_off;      // captured event is a note-off
    logic held_nz;     // pointed voice holds a note
    logic map_hit;     // captured note is mapped
    logic out_free;    // output register can load this cycle
  } status_t;

endpackage

// ===== hw/rtl/svalloc_ctrl.sv =====
// Sequencer for the voice allocator: accepts an event, then issues the
// emit commands to the datapath. Depends on svalloc_pkg.
module svalloc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  svalloc_pkg::status_t status,
  output svalloc_pkg::cmd_t    cmd
);
  import svalloc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ON   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Decode state into commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.is_off) begin
          if (!status.map_hit) begin
            state_nxt = S_IDLE;
          end else if (status.out_free) begin
            cmd.emit_off = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (status.out_free) begin
          if (status.held_nz) begin
            cmd.emit_steal = 1'b1;
            state_nxt      = S_ON;
          end else begin
            cmd.emit_on = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_ON: begin
        if (status.out_free) begin
          cmd.emit_on = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/svalloc_dp.sv =====
// Datapath for the voice allocator: rotating voice pointer, per-voice note
// registers, note map (valid flops plus voice memory), output register.
// Depends on svalloc_pkg.
module svalloc_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [svalloc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                  in_tuser,
  input  svalloc_pkg::cmd_t                     cmd,
  output svalloc_pkg::status_t                  status,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [svalloc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                  out_tuser,
  output logic                                  out_tlast
);
  import svalloc_pkg::*;

  // Captured event
  logic              op_r;
  logic [NOTE_W-1:0] note_r;
  logic [VEL_W-1:0]  vel_r;

  // Allocation state
  logic [VOICE_W-1:0] ptr_r;
  logic [VOICE_W-1:0] ptr_nxt;
  logic [NOTE_W-1:0]  voice_note_r [VOICES];
  logic [NOTES-1:0]   map_valid_r;
  logic [VOICE_W-1:0] map_voice_mem [NOTES];
  logic [VOICE_W-1:0] map_rd_r;

  // Output register
  logic               out_valid_r;
  logic [VOICE_W-1:0] out_voice_r;
  logic               out_kind_r;
  logic [NOTE_W-1:0]  out_note_r;
  logic [VEL_W-1:0]   out_vel_r;
  logic               out_last_r;

  logic [NOTE_W-1:0]     in_note;
  logic [VEL_W-1:0]      in_vel;
  logic [NOTE_W-1:0]     held;
  logic [NOTE_IDX_W-1:0] held_idx;
  logic [NOTE_IDX_W-1:0] note_idx;
  logic [NOTE_IDX_W-1:0] in_note_idx;
  logic                  out_free;

  assign in_note     = in_tdata[NOTE_W-1:0];
  assign in_vel      = in_tdata[NOTE_W +: VEL_W];
  assign in_note_idx = NOTE_IDX_W'(in_note);
  assign note_idx    = NOTE_IDX_W'(note_r);
  assign held        = voice_note_r[ptr_r];
  assign held_idx    = NOTE_IDX_W'(held);
  assign out_free    = !out_valid_r || out_tready;
  assign ptr_nxt     = (ptr_r == '0) ? VOICE_W'(VOICES - 1) : ptr_r - 1'b1;

  assign status.is_off   = (op_r == KIND_NOTE_OFF);
  assign status.held_nz  = (held != '0);
  assign status.map_hit  = map_valid_r[note_idx];
  assign status.out_free = out_free;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_tuser;
      note_r <= in_note;
      vel_r  <= in_vel;
    end
  end

  // Note-to-voice memory: write on note-on, registered read on capture
  always_ff @(posedge clk) begin
    if (cmd.emit_on) begin
      map_voice_mem[note_idx] <= ptr_r;
    end
    if (cmd.capture) begin
      map_rd_r <= map_voice_mem[in_note_idx];
    end
  end

  // Pointer, voice notes and map valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= VOICE_W'(VOICES - 1);
      map_valid_r <= '0;
      for (int i = 0; i < VOICES; i++) begin
        voice_note_r[i] <= '0;
      end
    end else begin
      if (cmd.emit_steal) begin
        map_valid_r[held_idx] <= 1'b0;
      end
      if (cmd.emit_on) begin
        ptr_r                 <= ptr_nxt;
        voice_note_r[ptr_r]   <= note_r;
        map_valid_r[note_idx] <= 1'b1;
      end
      if (cmd.emit_off) begin
        voice_note_r[map_rd_r] <= '0;
        map_valid_r[note_idx]  <= 1'b0;
      end
    end
  end

  // Output register: load on any emit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_steal || cmd.emit_on || cmd.emit_off) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_steal) begin
      out_voice_r <= ptr_r;
      out_kind_r  <= KIND_NOTE_OFF;
      out_note_r  <= held;
      out_vel_r   <= '0;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_on) begin
      out_voice_r <= ptr_r;
      out_kind_r  <= KIND_NOTE_ON;
      out_note_r  <= note_r;
      out_vel_r   <= vel_r;
      out_last_r  <= 1'b1;
    end else if (cmd.emit_off) begin
      out_voice_r <= map_rd_r;
      out_kind_r  <= KIND_NOTE_OFF;
      out_note_r  <= note_r;
      out_vel_r   <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_vel_r, out_note_r,
                       VOICE_OUT_W'(out_voice_r)};

endmodule

// ===== hw/rtl/synth_voice_allocator.sv =====
// Top level of the polyphonic voice allocator with voice stealing.
// Instantiates svalloc_ctrl and svalloc_dp; depends on svalloc_pkg.
//
// Channel  Dir  Handshake          Contents
// in_      in   tvalid/tready      tuser = op, tdata = note, velocity
// out_     out  tvalid/tready      tuser = kind, tlast = last,
//                                  tdata = voice, note, velocity
//
// An event is accepted, then looked up and emitted (an unmapped note-off emits
// nothing); a stealing note-on sends the old note-off, then its note-on, each via the output register.
// The map lookup is a registered memory read issued in the accept cycle.
// Reset sets the pointer to the last voice and clears voice notes and all map
// valid bits at once.
// A stalled output holds the sequencer at its next emit; no input is taken
// until that emit is done.
module synth_voice_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [svalloc_pkg::IN_TDATA_W-1:0]  in_tdata,  // note[6:0], velocity[13:7]
  input  logic                                in_tuser,  // op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [svalloc_pkg::OUT_TDATA_W-1:0] out_tdata, // voice[2:0], note[9:3], vel[16:10]
  output logic                                out_tuser, // kind
  output logic                                out_tlast
);
  import svalloc_pkg::*;

  cmd_t    cmd;
  status_t status;

  svalloc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  svalloc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  // One event in flight: no accept directly after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an event is in flight");

  // At most one emit command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_steal, cmd.emit_on, cmd.emit_off}))
    else $error("conflicting emit commands");

  // A non-final result is always the steal note-off
  a_first_is_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tuser == KIND_NOTE_OFF))
    else $error("non-final result is not a note-off");

  // Note-off results carry zero velocity
  a_off_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_NOTE_OFF) |-> (out_tdata[OUT_VEL_LSB +: VEL_W] == '0))
    else $error("note-off with nonzero velocity");
`endif

endmodule
